@@ hw/rtl/ctec_pkg.sv @@
// Shared types, constants and tables for the civil time / epoch converter.
// Used by ctec_encode, ctec_decode and civil_time_epoch_converter_top; no dependencies.
`default_nettype none

package ctec_pkg;

	localparam int STAGES = 7;

	localparam logic CMD_DECODE = 1'b0;
	localparam logic CMD_ENCODE = 1'b1;

	localparam logic [11:0] YEAR_MIN = 12'd1970;
	localparam logic [11:0] YEAR_MAX = 12'd2038;
	localparam logic [11:0] YEAR_BASE = 12'd1968;
	localparam logic [31:0] DECODE_LIMIT = 32'd2177452799;

	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
	localparam logic [5:0] SEC_PER_MIN = 6'd60;

	// Reciprocals for constant division, each exact over the range it sees.
	localparam logic [25:0] RECIP_675 = 26'd50903317;
	localparam logic [12:0] RECIP_225 = 13'd4661;
	localparam logic [17:0] RECIP_1461 = 18'd183735;
	localparam logic [15:0] RECIP_7 = 16'd37450;
	localparam logic [10:0] RECIP_15 = 11'd1093;
	localparam logic [13:0] RECIP_25 = 14'd10486;
	localparam logic [7:0] RECIP_10 = 8'd205;

	localparam logic [11:0] YEAR_BIAS = 12'd2687;
	localparam logic [9:0] WEEKDAY_BIAS = 10'd676;
	localparam logic [16:0] DAY_BIAS = 17'd67275;
	localparam logic [15:0] DAYS_PER_CENTURY = 16'd36525;
	localparam logic [8:0] MONTH_SPAN = 9'd306;

	typedef struct packed {
		logic [STAGES-1:0] load;
	} pipe_ctl_t;

	typedef struct packed {
		logic [10:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} dec_fields_t;

	// Days before the first of the month in a common year. Month zero is never used.
	function automatic logic [8:0] days_before_month(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd1: d = 9'd0;
			4'd2: d = 9'd31;
			4'd3: d = 9'd59;
			4'd4: d = 9'd90;
			4'd5: d = 9'd120;
			4'd6: d = 9'd151;
			4'd7: d = 9'd181;
			4'd8: d = 9'd212;
			4'd9: d = 9'd243;
			4'd10: d = 9'd273;
			4'd11: d = 9'd304;
			4'd12: d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ctec_encode.sv @@
// Two-stage encode datapath: civil date and time to seconds since 1970.
// Depends on ctec_pkg for the month table and stage controls.
`default_nettype none

module ctec_encode (
	input  wire logic              clk,
	input  wire ctec_pkg::pipe_ctl_t ctl,
	input  wire logic [11:0]       year,
	input  wire logic [3:0]        month,
	input  wire logic [4:0]        day,
	input  wire logic [4:0]        hour,
	input  wire logic [5:0]        minute,
	input  wire logic [5:0]        second,
	output logic [31:0]            epoch_s2
);

	logic [6:0]  dy;
	logic [6:0]  dy_m2;
	logic [14:0] year_days;
	logic        leap_adj;
	logic [15:0] total_nx;
	logic [15:0] total_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;
	logic [5:0]  second_s1;
	logic [31:0] epoch_nx;

	always_comb begin
		dy = 7'(year - ctec_pkg::YEAR_BASE);
		dy_m2 = dy - 7'd2;
		year_days = 15'(dy_m2) * 15'd365 + 15'(dy[6:2]);
		leap_adj = (year[1:0] == 2'b00) && (month <= 4'd2);
		total_nx = 16'(year_days) + 16'(ctec_pkg::days_before_month(month)) + 16'(day)
			- 16'd1 - 16'(leap_adj);
	end

	always_comb begin
		epoch_nx = 32'(total_s1) * 32'(ctec_pkg::SEC_PER_DAY)
			+ 32'(hour_s1) * 32'(ctec_pkg::SEC_PER_HOUR)
			+ 32'(minute_s1) * 32'(ctec_pkg::SEC_PER_MIN)
			+ 32'(second_s1);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			total_s1 <= total_nx;
			hour_s1 <= hour;
			minute_s1 <= minute;
			second_s1 <= second;
		end
		if (ctl.load[1]) begin
			epoch_s2 <= epoch_nx;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ctec_decode.sv @@
// Six-stage decode datapath: seconds since 1970 to date, time and weekday.
// Depends on ctec_pkg for constants, reciprocals and the field struct.
`default_nettype none

module ctec_decode (
	input  wire logic                clk,
	input  wire ctec_pkg::pipe_ctl_t ctl,
	input  wire logic [31:0]         ts,
	output ctec_pkg::dec_fields_t    fields
);

	// Stage 1
	logic [50:0] days_prod;
	logic [31:0] ts_s1;
	logic [14:0] days_s1;
	// Stage 2
	logic [31:0] day_sec;
	logic [16:0] rem_s2;
	logic [16:0] x_s2;
	logic [14:0] wdv_s2;
	logic [14:0] days_s2;
	// Stage 3
	logic [25:0] hour_prod;
	logic [34:0] year_prod;
	logic [29:0] wd_prod;
	logic [16:0] rem_s3;
	logic [4:0]  hour_s3;
	logic [6:0]  yq_s3;
	logic [11:0] wq_s3;
	logic [14:0] wdv_s3;
	logic [14:0] days_s3;
	// Stage 4
	logic [16:0] hour_sec;
	logic [21:0] r_base;
	logic [21:0] r_sub;
	logic [14:0] wq7;
	logic [11:0] rem2_s4;
	logic [15:0] r_s4;
	logic [2:0]  wd_s4;
	logic [6:0]  yq_s4;
	logic [4:0]  hour_s4;
	// Stage 5
	logic [19:0] min_prod;
	logic [27:0] q_prod;
	logic [11:0] rem2_s5;
	logic [5:0]  min_s5;
	logic [8:0]  q_s5;
	logic [2:0]  wd_s5;
	logic [6:0]  yq_s5;
	logic [4:0]  hour_s5;
	// Stage 6
	logic [11:0] min_sec;
	logic [11:0] d6;
	logic [3:0]  m_nx;
	logic [5:0]  sec_s6;
	logic [5:0]  min_s6;
	logic [3:0]  m_s6;
	logic [8:0]  q_s6;
	logic [2:0]  wd_s6;
	logic [6:0]  yq_s6;
	logic [4:0]  hour_s6;
	// Output
	logic [11:0] dn_full;
	logic [8:0]  dn;
	logic [17:0] day_prod;

	assign days_prod = 51'(ts[31:7]) * 51'(ctec_pkg::RECIP_675);
	assign day_sec = 32'(days_s1) * 32'(ctec_pkg::SEC_PER_DAY);
	assign hour_prod = 26'(rem_s2[16:4]) * 26'(ctec_pkg::RECIP_225);
	assign year_prod = 35'(x_s2) * 35'(ctec_pkg::RECIP_1461);
	assign wd_prod = 30'(wdv_s2) * 30'(ctec_pkg::RECIP_7);
	assign hour_sec = 17'(hour_s3) * 17'(ctec_pkg::SEC_PER_HOUR);
	assign r_base = 22'(days_s3) * 22'd100 + 22'(ctec_pkg::DAY_BIAS);
	assign r_sub = 22'(yq_s3) * 22'(ctec_pkg::DAYS_PER_CENTURY);
	assign wq7 = 15'(wq_s3) * 15'd7;
	assign min_prod = 20'(rem2_s4[11:2]) * 20'(ctec_pkg::RECIP_15);
	assign q_prod = 28'(r_s4[15:2]) * 28'(ctec_pkg::RECIP_25);
	assign min_sec = 12'(min_s5) * 12'(ctec_pkg::SEC_PER_MIN);
	assign d6 = 12'(q_s5) * 12'd10 - 12'd6;

	// The month index counts how many month boundaries the scaled day has passed.
	always_comb begin
		m_nx = 4'd0;
		for (int k = 1; k <= 11; k++) begin
			if (d6 >= 12'(k * 306)) begin
				m_nx = m_nx + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			ts_s1 <= ts;
			days_s1 <= days_prod[49:35];
		end
		if (ctl.load[1]) begin
			rem_s2 <= 17'(ts_s1 - day_sec);
			x_s2 <= 17'({days_s1, 2'b00}) + 17'(ctec_pkg::YEAR_BIAS);
			wdv_s2 <= days_s1 + 15'(ctec_pkg::WEEKDAY_BIAS);
			days_s2 <= days_s1;
		end
		if (ctl.load[2]) begin
			rem_s3 <= rem_s2;
			hour_s3 <= hour_prod[24:20];
			yq_s3 <= year_prod[34:28];
			wq_s3 <= wd_prod[29:18];
			wdv_s3 <= wdv_s2;
			days_s3 <= days_s2;
		end
		if (ctl.load[3]) begin
			rem2_s4 <= 12'(rem_s3 - hour_sec);
			r_s4 <= 16'(r_base - r_sub);
			wd_s4 <= 3'(wdv_s3 - wq7) + 3'd1;
			yq_s4 <= yq_s3;
			hour_s4 <= hour_s3;
		end
		if (ctl.load[4]) begin
			rem2_s5 <= rem2_s4;
			min_s5 <= min_prod[19:14];
			q_s5 <= q_prod[26:18];
			wd_s5 <= wd_s4;
			yq_s5 <= yq_s4;
			hour_s5 <= hour_s4;
		end
		if (ctl.load[5]) begin
			sec_s6 <= 6'(rem2_s5 - min_sec);
			min_s6 <= min_s5;
			m_s6 <= m_nx;
			q_s6 <= q_s5;
			wd_s6 <= wd_s5;
			yq_s6 <= yq_s5;
			hour_s6 <= hour_s5;
		end
	end

	always_comb begin
		dn_full = 12'(q_s6) * 12'd10 + 12'd4 - 12'(m_s6) * 12'(ctec_pkg::MONTH_SPAN);
		dn = dn_full[8:0];
		day_prod = 18'(dn) * 18'(ctec_pkg::RECIP_10);
		fields.year = 11'(ctec_pkg::YEAR_BASE) + 11'(yq_s6) + 11'(m_s6 >= 4'd10);
		fields.month = (m_s6 >= 4'd10) ? (m_s6 - 4'd9) : (m_s6 + 4'd3);
		fields.day = day_prod[15:11];
		fields.weekday = wd_s6;
		fields.hour = hour_s6;
		fields.minute = min_s6;
		fields.second = sec_s6;
	end

endmodule

`default_nettype wire

@@ hw/rtl/civil_time_epoch_converter_top.sv @@
// Top level of the civil time / epoch converter: handshake, stage control and result select.
// Depends on ctec_pkg, ctec_encode and ctec_decode.
`default_nettype none

// Converts seconds since 1970-01-01 00:00:00 to a civil date, time and weekday, or a civil
// date and time back to seconds, as the command bit selects. Each request passes through
// seven register stages, and one request can be accepted every cycle while the output is
// not stalled. The depth is set by the decode path, which divides by constants through
// reciprocal multiplies. Each stage holds its item while the next one is full, so a
// stalled output fills the pipeline before in_ready falls. Out-of-range requests return
// range_error with all other fields zero.
module civil_time_epoch_converter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [31:0] epoch_seconds_in,
	input  wire logic [11:0] year_in,
	input  wire logic [3:0]  month_in,
	input  wire logic [4:0]  day_in,
	input  wire logic [4:0]  hour_in,
	input  wire logic [5:0]  minute_in,
	input  wire logic [5:0]  second_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      epoch_seconds_out,
	output logic [10:0]      year_out,
	output logic [3:0]       month_out,
	output logic [4:0]       day_out,
	output logic [2:0]       weekday_out,
	output logic [4:0]       hour_out,
	output logic [5:0]       minute_out,
	output logic [5:0]       second_out,
	output logic             range_error
);

	ctec_pkg::pipe_ctl_t             ctl;
	logic [ctec_pkg::STAGES-1:0]     vld_q;
	logic                            enc_err;
	logic                            dec_err;
	logic [31:0]                     enc_epoch_s2;
	ctec_pkg::dec_fields_t           dec_fields;
	ctec_pkg::dec_fields_t           dec_sel;
	logic [31:0]                     epoch_sel;
	logic                            cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	logic                            err_s1, err_s2, err_s3, err_s4, err_s5, err_s6;
	logic [31:0]                     epoch_s3, epoch_s4, epoch_s5, epoch_s6;
	logic [31:0]                     epoch_s7;
	ctec_pkg::dec_fields_t           dec_s7;
	logic                            err_s7;

	always_comb begin
		ctl.load[ctec_pkg::STAGES-1] = !vld_q[ctec_pkg::STAGES-1] || out_ready;
		for (int i = ctec_pkg::STAGES - 2; i >= 0; i--) begin
			ctl.load[i] = !vld_q[i] || ctl.load[i+1];
		end
	end

	assign in_ready = ctl.load[0];
	assign out_valid = vld_q[ctec_pkg::STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.load[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < ctec_pkg::STAGES; i++) begin
				if (ctl.load[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_comb begin
		enc_err = (year_in < ctec_pkg::YEAR_MIN) || (year_in > ctec_pkg::YEAR_MAX)
			|| (month_in < 4'd1) || (month_in > 4'd12) || (day_in < 5'd1)
			|| (hour_in > 5'd23) || (minute_in > 6'd59) || (second_in > 6'd59);
		dec_err = epoch_seconds_in > ctec_pkg::DECODE_LIMIT;
	end

	ctec_encode u_encode (
		.clk      (clk),
		.ctl      (ctl),
		.year     (year_in),
		.month    (month_in),
		.day      (day_in),
		.hour     (hour_in),
		.minute   (minute_in),
		.second   (second_in),
		.epoch_s2 (enc_epoch_s2)
	);

	ctec_decode u_decode (
		.clk    (clk),
		.ctl    (ctl),
		.ts     (epoch_seconds_in),
		.fields (dec_fields)
	);

	always_comb begin
		epoch_sel = '0;
		dec_sel = '0;
		if (!err_s6) begin
			if (cmd_s6 == ctec_pkg::CMD_ENCODE) begin
				epoch_sel = epoch_s6;
			end else begin
				dec_sel = dec_fields;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			cmd_s1 <= command;
			err_s1 <= (command == ctec_pkg::CMD_ENCODE) ? enc_err : dec_err;
		end
		if (ctl.load[1]) begin
			cmd_s2 <= cmd_s1;
			err_s2 <= err_s1;
		end
		if (ctl.load[2]) begin
			cmd_s3 <= cmd_s2;
			err_s3 <= err_s2;
			epoch_s3 <= enc_epoch_s2;
		end
		if (ctl.load[3]) begin
			cmd_s4 <= cmd_s3;
			err_s4 <= err_s3;
			epoch_s4 <= epoch_s3;
		end
		if (ctl.load[4]) begin
			cmd_s5 <= cmd_s4;
			err_s5 <= err_s4;
			epoch_s5 <= epoch_s4;
		end
		if (ctl.load[5]) begin
			cmd_s6 <= cmd_s5;
			err_s6 <= err_s5;
			epoch_s6 <= epoch_s5;
		end
		if (ctl.load[6]) begin
			epoch_s7 <= epoch_sel;
			dec_s7 <= dec_sel;
			err_s7 <= err_s6;
		end
	end

	assign epoch_seconds_out = epoch_s7;
	assign year_out = dec_s7.year;
	assign month_out = dec_s7.month;
	assign day_out = dec_s7.day;
	assign weekday_out = dec_s7.weekday;
	assign hour_out = dec_s7.hour;
	assign minute_out = dec_s7.minute;
	assign second_out = dec_s7.second;
	assign range_error = err_s7;

endmodule

`default_nettype wire
